// File: rtl/sbdix_pkg.sv
// Package for the session-reply parser: character codes, field and status
// codes and the parse-state type. No dependencies.
package sbdix_pkg;

  // Character codes
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Reply field codes
  localparam logic [2:0] FLD_HEADER = 3'd0;
  localparam logic [2:0] FLD_MO     = 3'd1;
  localparam logic [2:0] FLD_SKIP2  = 3'd2;
  localparam logic [2:0] FLD_MT     = 3'd3;
  localparam logic [2:0] FLD_SKIP4  = 3'd4;
  localparam logic [2:0] FLD_SKIP5  = 3'd5;
  localparam logic [2:0] FLD_QUEUE  = 3'd6;

  // Incoming status codes
  localparam logic [1:0] MT_NONE     = 2'd0;
  localparam logic [1:0] MT_RECEIVED = 2'd1;
  localparam logic [1:0] MT_ERROR    = 2'd2;

  localparam logic [6:0] QUEUE_MAX = 7'd127;

  // Register map
  localparam int unsigned      PADDR_W          = 3;
  localparam logic [0:0]       REG_EXPECTED     = 1'b0;
  localparam logic [3:0]       EXPECTED_RESET   = 4'd5;

  typedef struct packed {
    logic [3:0] terminator_count;
    logic [2:0] field_index;
    logic       sent_flag;
    logic       digit_seen;
    logic [1:0] receive_status;
    logic [6:0] queue_accumulator;
    logic       number_started;
    logic       number_done;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    terminator_count:  4'd0,
    field_index:       FLD_HEADER,
    sent_flag:         1'b1,
    digit_seen:        1'b0,
    receive_status:    MT_NONE,
    queue_accumulator: 7'd0,
    number_started:    1'b0,
    number_done:       1'b0
  };

  // Result item as packed on the output tdata (highest bits first)
  typedef struct packed {
    logic [6:0] queued_count;
    logic [1:0] mt_status;
    logic       sent_ok;
  } result_t;

endpackage

// File: rtl/sbdix_response_parser_top.sv
// Top level of the session-reply parser: byte stream in, one result item per
// framed reply out, APB register for the terminator count.
// Depends on sbdix_pkg.
//
//  channel   direction  payload                                  handshake
//  s_*       in         tdata[7:0] rx_byte, tuser[0] restart     tvalid/tready
//  m_*       out        tdata[0] sent_ok, [2:1] mt_status,       tvalid/tready
//                       [9:3] queued_count, [15:10] zero
//  APB       in/out     paddr[2:0], pwdata/prdata[3:0] used      pready tied high
//
// One byte is taken per cycle while s_tready is high; the parse-state
// update and the terminator compare sit in one combinational step ahead of
// the state registers. A result is registered on m_* or, while m_* holds a
// stalled result, in the one-entry skid stage; output register plus skid
// stage keep s_tready high while a result waits; s_tready drops only when both hold a result.
// rst is synchronous: it clears parse state, both result slots and sets
// expected_terminators to 5.
module sbdix_response_parser_top (
  input  logic        clk,
  input  logic        rst,
  // byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] restart
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] sent_ok, [2:1] mt_status, [9:3] queued_count
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [sbdix_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]              expected_terminators;
  sbdix_pkg::parse_state_t state;
  sbdix_pkg::parse_state_t state_next;
  sbdix_pkg::parse_state_t cur;
  sbdix_pkg::parse_state_t parsed;
  sbdix_pkg::result_t      result_next;
  sbdix_pkg::result_t      out_data;
  sbdix_pkg::result_t      skid_data;
  logic                    out_valid;
  logic                    skid_valid;
  logic                    fire;
  logic                    accept;
  logic                    produce;
  logic                    take;
  logic [7:0]              b;
  logic [10:0]             qsum;

  // ---------------------------------------------------------------------
  // Configuration port: register 0 is expected_terminators
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_terminators <= sbdix_pkg::EXPECTED_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == sbdix_pkg::REG_EXPECTED)) begin
      expected_terminators <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == sbdix_pkg::REG_EXPECTED) begin
      prdata = {28'd0, expected_terminators};
    end
  end

  // ---------------------------------------------------------------------
  // Byte parse: restart clears first, then the byte updates the fields,
  // then terminators are counted on the updated state.
  // ---------------------------------------------------------------------
  assign b = s_tdata;

  always_comb begin
    cur    = s_tuser[0] ? sbdix_pkg::PARSE_CLEAR : state;
    parsed = cur;
    qsum   = ({4'd0, cur.queue_accumulator} * 11'd10) + {7'd0, b[3:0]};

    case (cur.field_index)
      sbdix_pkg::FLD_HEADER: begin
        if (b == sbdix_pkg::CH_COLON) parsed.field_index = sbdix_pkg::FLD_MO;
      end
      sbdix_pkg::FLD_MO: begin
        if (b == sbdix_pkg::CH_SPACE) begin
          // skip padding
        end else if (b == sbdix_pkg::CH_COMMA) begin
          parsed.digit_seen  = 1'b0;
          parsed.field_index = sbdix_pkg::FLD_SKIP2;
        end else if (b == sbdix_pkg::CH_ZERO || b == sbdix_pkg::CH_ONE ||
                     b == sbdix_pkg::CH_TWO) begin
          // a second status digit spoils the flag
          parsed.sent_flag  = !cur.digit_seen;
          parsed.digit_seen = 1'b1;
        end else begin
          parsed.sent_flag  = 1'b0;
          parsed.digit_seen = 1'b1;
        end
      end
      sbdix_pkg::FLD_MT: begin
        if (b == sbdix_pkg::CH_COMMA) begin
          parsed.field_index = sbdix_pkg::FLD_SKIP4;
        end else if (b == sbdix_pkg::CH_SPACE) begin
          // skip padding
        end else if (b == sbdix_pkg::CH_ZERO) begin
          parsed.receive_status = sbdix_pkg::MT_NONE;
        end else if (b == sbdix_pkg::CH_ONE) begin
          parsed.receive_status = sbdix_pkg::MT_RECEIVED;
        end else begin
          parsed.receive_status = sbdix_pkg::MT_ERROR;
        end
      end
      sbdix_pkg::FLD_SKIP2, sbdix_pkg::FLD_SKIP4, sbdix_pkg::FLD_SKIP5: begin
        if (b == sbdix_pkg::CH_COMMA) parsed.field_index = cur.field_index + 3'd1;
      end
      default: begin
        // queued-message count; only read when a message came in
        if (cur.receive_status == sbdix_pkg::MT_RECEIVED && !cur.number_done) begin
          if (b >= sbdix_pkg::CH_ZERO && b <= sbdix_pkg::CH_NINE) begin
            parsed.queue_accumulator = (qsum > {4'd0, sbdix_pkg::QUEUE_MAX}) ?
                                       sbdix_pkg::QUEUE_MAX : qsum[6:0];
            parsed.number_started = 1'b1;
          end else if (b == sbdix_pkg::CH_SPACE && !cur.number_started) begin
            // leading space
          end else begin
            parsed.number_done = 1'b1;
          end
        end
      end
    endcase

    fire = 1'b0;
    if (b == sbdix_pkg::CH_CR || b == sbdix_pkg::CH_RPAREN) begin
      parsed.terminator_count = cur.terminator_count + 4'd1;
      fire = (parsed.terminator_count == expected_terminators);
    end

    result_next.sent_ok      = parsed.sent_flag;
    result_next.mt_status    = parsed.receive_status;
    result_next.queued_count = (parsed.receive_status == sbdix_pkg::MT_RECEIVED) ?
                               parsed.queue_accumulator : 7'd0;

    // the reply is complete: start afresh
    state_next = fire ? sbdix_pkg::PARSE_CLEAR : parsed;
  end

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign produce  = accept && fire;
  assign take     = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbdix_pkg::PARSE_CLEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register with a one-entry skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        // advance the waiting item; no new item is taken while skid is full
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= skid_valid ? skid_data : result_next;
    end else if (produce && !out_valid) begin
      out_data <= result_next;
    end
    if (produce && out_valid && !take) begin
      skid_data <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_data};

endmodule

// File: rtl/sbdix_checker.sv
// Port-level checker for the session-reply parser, bound to the top level.
// Depends on sbdix_response_parser_top's port list only.
module sbdix_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $past(m_tvalid && !m_tready)) |-> (m_tvalid && $stable(m_tdata)))
    else $error("result item changed while stalled");

  // Backpressure on the input only while a result is held on the output
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // Status code is never the unused value
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:1] != 2'd3))
    else $error("invalid mt_status");

  // Count and the unused upper bits are zero unless a message was received
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:1] != 2'd1) |-> (m_tdata[9:3] == 7'd0 && m_tdata[15:10] == 6'd0))
    else $error("queued_count set without a received message");

endmodule

bind sbdix_response_parser_top sbdix_checker u_sbdix_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
